// File: src/kc_pkg.sv
package kc_pkg;

   localparam logic [4:0] KEY_SIGN   = 5'd10;
   localparam logic [4:0] KEY_ADD    = 5'd11;
   localparam logic [4:0] KEY_ROOT   = 5'd16;
   localparam logic [4:0] KEY_ON     = 5'd17;
   localparam logic [4:0] KEY_DIGITS = 5'd10;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_EQ  = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      MODE_MUL,
      MODE_DIV,
      MODE_SQRT
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_APPLY,
      ST_POST,
      ST_ROOT
   } state_type;

   typedef struct packed {
      logic     start;
      mode_type mode;
   } ctl_type;

endpackage

// File: src/kc_serial_unit.sv
module kc_serial_unit #(
   parameter int NUM_WIDTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  kc_pkg::ctl_type      ctl,
   input  logic [NUM_WIDTH-1:0] opa,
   input  logic [NUM_WIDTH-1:0] opb,
   output logic                 done,
   output logic [NUM_WIDTH-1:0] result
);

   localparam int SW = (NUM_WIDTH + 1) / 2;
   localparam int VW = 2 * SW;
   localparam int CW = $clog2(NUM_WIDTH + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   kc_pkg::mode_type     mode_ff, mode_in;
   logic                 neg_ff, neg_in;
   logic [NUM_WIDTH:0]   rem_ff, rem_in;
   logic [NUM_WIDTH-1:0] d_ff, d_in;
   logic [NUM_WIDTH-1:0] q_ff, q_in;
   logic [VW-1:0]        v_ff, v_in;
   logic [NUM_WIDTH:0]   shifted;
   logic [NUM_WIDTH:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      mode_in = mode_ff;
      neg_in  = neg_ff;
      rem_in  = rem_ff;
      d_in    = d_ff;
      q_in    = q_ff;
      v_in    = v_ff;
      shifted = '0;
      trial   = '0;
      if (ctl.start) begin
         busy_in = 1'b1;
         mode_in = ctl.mode;
         rem_in  = '0;
         neg_in  = 1'b0;
         v_in    = VW'(opa);
         case (ctl.mode)
            kc_pkg::MODE_MUL: begin
               cnt_in = CW'(NUM_WIDTH);
               d_in   = opa;
               q_in   = opb;
            end
            kc_pkg::MODE_DIV: begin
               cnt_in = CW'(NUM_WIDTH);
               d_in   = opb[NUM_WIDTH-1] ? (~opb + 1'b1) : opb;
               q_in   = opa[NUM_WIDTH-1] ? (~opa + 1'b1) : opa;
               neg_in = opa[NUM_WIDTH-1] ^ opb[NUM_WIDTH-1];
            end
            default: begin
               cnt_in = CW'(SW);
               q_in   = '0;
            end
         endcase
      end else if (busy_ff) begin
         case (mode_ff)
            kc_pkg::MODE_MUL: begin
               // Shift-and-add, one multiplier bit per cycle, low half only.
               if (q_ff[0]) begin
                  rem_in = {1'b0, rem_ff[NUM_WIDTH-1:0] + d_ff};
               end
               d_in = {d_ff[NUM_WIDTH-2:0], 1'b0};
               q_in = {1'b0, q_ff[NUM_WIDTH-1:1]};
            end
            kc_pkg::MODE_DIV: begin
               shifted = {rem_ff[NUM_WIDTH-1:0], q_ff[NUM_WIDTH-1]};
               if (shifted >= {1'b0, d_ff}) begin
                  rem_in = shifted - {1'b0, d_ff};
                  q_in   = {q_ff[NUM_WIDTH-2:0], 1'b1};
               end else begin
                  rem_in = shifted;
                  q_in   = {q_ff[NUM_WIDTH-2:0], 1'b0};
               end
            end
            default: begin
               // Digit-by-digit root, one pair of radicand bits per cycle.
               shifted = {rem_ff[NUM_WIDTH-2:0], v_ff[VW-1:VW-2]};
               trial   = {q_ff[NUM_WIDTH-2:0], 2'b01};
               if (shifted >= trial) begin
                  rem_in = shifted - trial;
                  q_in   = {q_ff[NUM_WIDTH-2:0], 1'b1};
               end else begin
                  rem_in = shifted;
                  q_in   = {q_ff[NUM_WIDTH-2:0], 1'b0};
               end
               v_in = {v_ff[VW-3:0], 2'b00};
            end
         endcase
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         mode_ff <= kc_pkg::MODE_MUL;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         mode_ff <= mode_in;
      end
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      d_ff   <= d_in;
      q_ff   <= q_in;
      v_ff   <= v_in;
   end

   assign done = done_ff;

   always_comb begin
      case (mode_ff)
         kc_pkg::MODE_MUL: result = rem_ff[NUM_WIDTH-1:0];
         kc_pkg::MODE_DIV: result = neg_ff ? (~q_ff + 1'b1) : q_ff;
         default:          result = q_ff;
      endcase
   end

endmodule

// File: src/keypad_calculator_core_unit.sv
// Digit, sign, on and ignored keys answer straight from the idle state; add, subtract and
// equals answer from the post state; multiply and divide first run the bit-serial unit in
// the apply state, and sqrt then runs the unit once more in the root state after the path
// before it. One key word is in flight at a time; the next is taken after the response word
// is taken. Synchronous reset gives accumulator 0, entry 0, pending equals, showing result
// set and error clear.
module keypad_calculator_core_unit #(
   parameter int NUM_WIDTH = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // key [4:0], zero [7:5]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata    // accumulator [63:0], entry [127:64],
                                     // pending_op [130:128], showing_result [131],
                                     // error [132], zero [135:133]
);

   kc_pkg::state_type    state_ff, state_in;
   logic [NUM_WIDTH-1:0] acc_ff, acc_in;
   logic [NUM_WIDTH-1:0] entry_ff, entry_in;
   kc_pkg::op_type       op_ff, op_in;
   logic                 show_ff, show_in;
   logic                 err_ff, err_in;
   logic [4:0]           key_ff, key_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   kc_pkg::ctl_type      ctl;
   logic                 unit_done;
   logic [NUM_WIDTH-1:0] unit_result;
   logic [4:0]           key;
   logic                 emit;

   kc_serial_unit #(.NUM_WIDTH(NUM_WIDTH)) u_serial (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .opa    (acc_ff),
      .opb    (entry_ff),
      .done   (unit_done),
      .result (unit_result)
   );

   assign req_tready = (state_ff == kc_pkg::ST_IDLE) && !rsp_valid_ff;
   assign key        = req_tdata[4:0];

   always_comb begin
      state_in   = state_ff;
      acc_in     = acc_ff;
      entry_in   = entry_ff;
      op_in      = op_ff;
      show_in    = show_ff;
      err_in     = err_ff;
      key_in     = key_ff;
      ctl.start  = 1'b0;
      ctl.mode   = kc_pkg::MODE_MUL;
      emit       = 1'b0;
      case (state_ff)
         kc_pkg::ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               key_in = key;
               if (key == kc_pkg::KEY_ON) begin
                  acc_in   = '0;
                  entry_in = '0;
                  op_in    = kc_pkg::OP_EQ;
                  show_in  = 1'b1;
                  err_in   = 1'b0;
                  emit     = 1'b1;
               end else if (err_ff) begin
                  emit = 1'b1;
               end else if (key < kc_pkg::KEY_DIGITS) begin
                  if (show_ff) begin
                     show_in = 1'b0;
                     if (op_ff == kc_pkg::OP_EQ) begin
                        acc_in = '0;
                     end
                  end
                  entry_in = {entry_ff[NUM_WIDTH-4:0], 3'b000}
                           + {entry_ff[NUM_WIDTH-2:0], 1'b0} + NUM_WIDTH'(key);
                  emit = 1'b1;
               end else if (key == kc_pkg::KEY_SIGN) begin
                  entry_in = ~entry_ff + 1'b1;
                  emit     = 1'b1;
               end else if (key >= kc_pkg::KEY_ADD && key <= kc_pkg::KEY_ROOT) begin
                  state_in = kc_pkg::ST_POST;
                  if (!show_ff) begin
                     entry_in = '0;
                     case (op_ff)
                        kc_pkg::OP_ADD: acc_in = acc_ff + entry_ff;
                        kc_pkg::OP_SUB: acc_in = acc_ff - entry_ff;
                        kc_pkg::OP_EQ:  acc_in = entry_ff;
                        kc_pkg::OP_MUL: begin
                           entry_in  = entry_ff;
                           ctl.start = 1'b1;
                           ctl.mode  = kc_pkg::MODE_MUL;
                           state_in  = kc_pkg::ST_APPLY;
                        end
                        kc_pkg::OP_DIV: begin
                           if (entry_ff == '0) begin
                              err_in = 1'b1;
                           end else begin
                              entry_in  = entry_ff;
                              ctl.start = 1'b1;
                              ctl.mode  = kc_pkg::MODE_DIV;
                              state_in  = kc_pkg::ST_APPLY;
                           end
                        end
                        default: err_in = 1'b1;
                     endcase
                  end
               end else begin
                  emit = 1'b1;
               end
            end
         end
         kc_pkg::ST_APPLY: begin
            if (unit_done) begin
               acc_in   = unit_result;
               entry_in = '0;
               state_in = kc_pkg::ST_POST;
            end
         end
         kc_pkg::ST_POST: begin
            show_in = 1'b1;
            if (key_ff == kc_pkg::KEY_ROOT) begin
               op_in = kc_pkg::OP_EQ;
               if (acc_ff[NUM_WIDTH-1]) begin
                  err_in   = 1'b1;
                  emit     = 1'b1;
                  state_in = kc_pkg::ST_IDLE;
               end else begin
                  ctl.start = 1'b1;
                  ctl.mode  = kc_pkg::MODE_SQRT;
                  state_in  = kc_pkg::ST_ROOT;
               end
            end else begin
               op_in    = kc_pkg::op_type'(3'(key_ff - kc_pkg::KEY_ADD));
               emit     = 1'b1;
               state_in = kc_pkg::ST_IDLE;
            end
         end
         kc_pkg::ST_ROOT: begin
            if (unit_done) begin
               acc_in   = unit_result;
               emit     = 1'b1;
               state_in = kc_pkg::ST_IDLE;
            end
         end
         default: state_in = kc_pkg::ST_IDLE;
      endcase
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kc_pkg::ST_IDLE;
         acc_ff       <= '0;
         entry_ff     <= '0;
         op_ff        <= kc_pkg::OP_EQ;
         show_ff      <= 1'b1;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         entry_ff     <= entry_in;
         op_ff        <= op_in;
         show_ff      <= show_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff <= key_in;
   end

   // State registers hold still until the response word is taken.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, err_ff, show_ff, op_ff,
                        64'($signed(entry_ff)), 64'($signed(acc_ff))};

endmodule
